[rtl/shv_pkg.sv]
`default_nettype none
package shv_pkg;

  // defaults for the top level parameters
  localparam int BUCKET_BITS_DEF = 12;
  localparam int MAX_NODES_DEF   = 4096;
  localparam int WORDS_MAX_DEF   = 4;

  // fixed field widths
  localparam int IDX_W  = 13;
  localparam int CFG_W  = 13;
  localparam int WORD_W = 32;

  // configuration register indexes
  localparam logic REG_WORDS     = 1'b0;
  localparam logic REG_MAX_NODES = 1'b1;

  // opcodes
  localparam logic OP_FIND   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // input side sequencer
  typedef enum logic [1:0] {
    S_IN,
    S_HASH,
    S_TBL
  } top_state_t;

  // table sequencer
  typedef enum logic [2:0] {
    T_CLEAR,
    T_IDLE,
    T_HEAD,
    T_NODE,
    T_RD,
    T_CMP,
    T_INS,
    T_DONE
  } tbl_state_t;

  // request from the input side to the table
  typedef struct packed {
    logic start;
    logic ack;
    logic op;
  } tbl_req_t;

  // status from the table
  typedef struct packed {
    logic idle;
    logic done;
    logic was_new;
    logic full;
  } tbl_rsp_t;

endpackage
`default_nettype wire

[rtl/state_vector_hash_set.sv]
`default_nettype none
// Hash set of state vectors. A vector arrives as words_per_state beats of one
// 32-bit word each, clamped to 1..WORDS_MAX; opcode is taken from the first
// beat (0 find, 1 find or insert). Each word goes through two multiply rounds
// and a done flag in the hash unit. After the last word the table reads the
// bucket head, then walks the chain node by node, reading and comparing the
// stored words one at a time, writes the words of a new node one at a time
// on an insert, and hands the result beat to the output register once that
// is free. After reset the bucket heads are cleared by a sweep over all
// 2**BUCKET_BITS buckets (4096 by default) during which no beat is taken;
// configuration writes are taken at any time.
module state_vector_hash_set import shv_pkg::*; #(
  parameter int BUCKET_BITS = BUCKET_BITS_DEF,
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int WORDS_MAX   = WORDS_MAX_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [31:0]      s_tdata,   // state_word[31:0]
  input  wire logic [0:0]       s_tuser,   // opcode
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [15:0]           m_tdata,   // node_index[12:0], zero pad
  output logic [1:0]            m_tuser,   // was_new, table_full
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int NODE_W = $clog2(MAX_NODES + 2);
  localparam int POS_W  = (WORDS_MAX > 1) ? $clog2(WORDS_MAX) : 1;
  localparam int CNT_W  = $clog2(WORDS_MAX + 1);
  localparam int LIM_W  = (NODE_W > CFG_W) ? NODE_W : CFG_W;

  logic [2:0]       words_per_state;
  logic [CFG_W-1:0] max_nodes;
  logic [CNT_W-1:0] n_eff;
  logic [LIM_W-1:0] limit;

  top_state_t state, state_next;

  logic [POS_W-1:0]  pos;
  logic              op, last, last_now, accept, hash_done, out_load;
  logic [WORD_W-1:0] pending [WORDS_MAX];
  logic [WORD_W-1:0] hash;
  logic [NODE_W-1:0] node_res;
  tbl_req_t          req;
  tbl_rsp_t          rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      words_per_state <= 3'd1;
      max_nodes       <= 13'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WORDS:     words_per_state <= cfg_data[2:0];
        REG_MAX_NODES: max_nodes <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped length and node limit
  always_comb begin
    if (words_per_state == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(words_per_state) > WORDS_MAX) begin
      n_eff = CNT_W'(WORDS_MAX);
    end else begin
      n_eff = CNT_W'(words_per_state);
    end
    limit = (LIM_W'(max_nodes) > LIM_W'(MAX_NODES)) ? LIM_W'(MAX_NODES)
                                                    : LIM_W'(max_nodes);
  end

  assign accept   = s_tvalid && s_tready;
  assign last_now = (32'(pos) + 1) >= 32'(n_eff);
  assign out_load = state == S_TBL && rsp.done && (!m_tvalid || m_tready);

  // word position, opcode and vector buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (accept) begin
      pos <= last_now ? '0 : pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending[pos] <= s_tdata;
      last         <= last_now;
      if (pos == '0) op <= s_tuser[0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    req.start  = 1'b0;
    req.ack    = 1'b0;
    req.op     = op;
    case (state)
      S_IN: begin
        s_tready = rsp.idle;
        if (accept) state_next = S_HASH;
      end
      S_HASH: begin
        if (hash_done) begin
          req.start  = last;
          state_next = last ? S_TBL : S_IN;
        end
      end
      S_TBL: begin
        req.ack = out_load;
        if (out_load) state_next = S_IN;
      end
      default: state_next = S_IN;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000, IDX_W'(node_res)};
      m_tuser <= {rsp.full, rsp.was_new};
    end
  end

  shv_hash #(
    .BUCKET_BITS(BUCKET_BITS)
  ) u_hash (
    .clk  (clk),
    .rst  (rst),
    .start(accept),
    .first(pos == '0),
    .word (s_tdata),
    .done (hash_done),
    .hash (hash)
  );

  shv_table #(
    .BUCKET_BITS(BUCKET_BITS),
    .MAX_NODES  (MAX_NODES),
    .WORDS_MAX  (WORDS_MAX),
    .NODE_W     (NODE_W),
    .POS_W      (POS_W),
    .CNT_W      (CNT_W),
    .LIM_W      (LIM_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .bucket  (hash[BUCKET_BITS-1:0]),
    .nwords  (n_eff),
    .limit   (limit),
    .pending (pending),
    .node_out(node_res)
  );

endmodule
`default_nettype wire

[rtl/shv_hash.sv]
`default_nettype none
module shv_hash import shv_pkg::*; #(
  parameter int BUCKET_BITS = BUCKET_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              first,
  input  wire logic [WORD_W-1:0] word,
  output logic                   done,
  output logic [WORD_W-1:0]      hash
);

  localparam logic [WORD_W-1:0] MUL_K = 32'd1234567;
  localparam logic [WORD_W-1:0] ADD_K = 32'd5555555;

  logic busy;
  logic fin;

  // one xorshift and multiply-add round
  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] h);
    logic [WORD_W-1:0] t;
    t = h ^ (h >> BUCKET_BITS);
    return t * MUL_K + ADD_K;
  endfunction

  // first round on the word beat, second round in the following cycle,
  // done flagged once the second round is in the register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      busy <= start;
      fin  <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hash <= mix(first ? word : (hash ^ word));
    end else if (busy) begin
      hash <= mix(hash);
    end
  end

  assign done = fin;

endmodule
`default_nettype wire

[rtl/shv_table.sv]
`default_nettype none
module shv_table import shv_pkg::*; #(
  parameter int BUCKET_BITS = BUCKET_BITS_DEF,
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int WORDS_MAX   = WORDS_MAX_DEF,
  parameter int NODE_W      = $clog2(MAX_NODES + 2),
  parameter int POS_W       = (WORDS_MAX > 1) ? $clog2(WORDS_MAX) : 1,
  parameter int CNT_W       = $clog2(WORDS_MAX + 1),
  parameter int LIM_W       = (NODE_W > CFG_W) ? NODE_W : CFG_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire tbl_req_t               req,
  output tbl_rsp_t                    rsp,
  input  wire logic [BUCKET_BITS-1:0] bucket,
  input  wire logic [CNT_W-1:0]       nwords,
  input  wire logic [LIM_W-1:0]       limit,
  input  wire logic [WORD_W-1:0]      pending [WORDS_MAX],
  output logic [NODE_W-1:0]           node_out
);

  localparam int BUCKETS = 1 << BUCKET_BITS;
  localparam int LINKS   = MAX_NODES + 1;
  localparam int WDEPTH  = (MAX_NODES + 1) * WORDS_MAX;
  localparam int WA      = $clog2(WDEPTH);
  localparam int LA      = $clog2(LINKS);

  // memories
  logic [NODE_W-1:0] heads [BUCKETS];
  logic [NODE_W-1:0] links [LINKS];
  logic [WORD_W-1:0] words [WDEPTH];

  tbl_state_t state, state_next;

  logic [NODE_W-1:0]      node, head_q, count, res_node;
  logic [POS_W-1:0]       k;
  logic [BUCKET_BITS-1:0] bucket_q, clr;
  logic [CNT_W-1:0]       nw_q;
  logic                   op_q, res_new, res_full;

  logic [NODE_W-1:0] head_rdata, link_rdata;
  logic [WORD_W-1:0] word_rdata;

  logic [NODE_W-1:0] new_node;
  logic              new_full, k_last, clr_last, word_eq;
  logic [WA-1:0]     rd_addr, wr_addr;

  assign new_node = count + 1'b1;
  assign new_full = LIM_W'(new_node) > limit;
  assign k_last   = (32'(k) + 1) >= 32'(nw_q);
  assign clr_last = clr == {BUCKET_BITS{1'b1}};
  assign word_eq  = word_rdata == pending[k];
  assign rd_addr  = WA'(node) * WA'(WORDS_MAX) + WA'(k);
  assign wr_addr  = WA'(new_node) * WA'(WORDS_MAX) + WA'(k);

  // bucket heads: cleared by the sweep, written on insert
  always_ff @(posedge clk) begin
    if (state == T_CLEAR) begin
      heads[clr] <= '0;
    end else if (state == T_INS && k == '0) begin
      heads[bucket_q] <= new_node;
    end
    head_rdata <= heads[bucket];
  end

  // chain links and stored words
  always_ff @(posedge clk) begin
    if (state == T_INS && k == '0) begin
      links[LA'(new_node)] <= head_q;
    end
    if (state == T_INS) begin
      words[wr_addr] <= pending[k];
    end
    link_rdata <= links[LA'(node)];
    word_rdata <= words[rd_addr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      T_CLEAR: if (clr_last) state_next = T_IDLE;
      T_IDLE:  if (req.start) state_next = T_HEAD;
      T_HEAD:  state_next = T_NODE;
      T_NODE: begin
        if (node != '0) begin
          state_next = T_RD;
        end else if (op_q == OP_INSERT && !new_full) begin
          state_next = T_INS;
        end else begin
          state_next = T_DONE;
        end
      end
      T_RD:  state_next = T_CMP;
      T_CMP: begin
        if (!word_eq) begin
          state_next = T_NODE;
        end else if (k_last) begin
          state_next = T_DONE;
        end else begin
          state_next = T_RD;
        end
      end
      T_INS:  if (k_last) state_next = T_DONE;
      T_DONE: if (req.ack) state_next = T_IDLE;
      default: state_next = T_CLEAR;
    endcase
  end

  // control and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      clr   <= '0;
    end else begin
      if (state == T_CLEAR) clr <= clr + 1'b1;
      if (state == T_INS && k_last) count <= new_node;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      T_IDLE: begin
        bucket_q <= bucket;
        op_q     <= req.op;
        nw_q     <= nwords;
      end
      T_HEAD: begin
        head_q <= head_rdata;
        node   <= head_rdata;
      end
      T_NODE: begin
        k <= '0;
        if (node == '0) begin
          res_node <= (op_q == OP_INSERT) ? new_node : '0;
          res_new  <= 1'b0;
          res_full <= (op_q == OP_INSERT) && new_full;
        end
      end
      T_CMP: begin
        if (!word_eq) begin
          node <= link_rdata;
        end else if (k_last) begin
          res_node <= node;
          res_new  <= 1'b0;
          res_full <= 1'b0;
        end else begin
          k <= k + 1'b1;
        end
      end
      T_INS: begin
        k <= k + 1'b1;
        if (k_last) begin
          res_node <= new_node;
          res_new  <= 1'b1;
          res_full <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp.idle    = state == T_IDLE;
    rsp.done    = state == T_DONE;
    rsp.was_new = res_new;
    rsp.full    = res_full;
  end

  assign node_out = res_node;

endmodule
`default_nettype wire

[rtl/shv_checker.sv]
`default_nettype none
module shv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [31:0] s_tdata,
  input wire logic [0:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        cfg_we,
  input wire logic        cfg_index,
  input wire logic [12:0] cfg_data
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // each word beat occupies the hash unit, so no beat is taken next cycle
  a_gap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("word taken while hash busy");

  // new and full never both
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("was_new and table_full both set");

  // a new or refused node carries a nonzero index
  a_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tdata[12:0] != 13'd0)
    else $error("zero index on insert result");

endmodule

bind state_vector_hash_set shv_checker u_chk (.*);
`default_nettype wire

[sim/state_vector_hash_set_tb.sv]
module state_vector_hash_set_tb;
  import shv_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int NWAY = 4;
  localparam int HBITS = 12;

  typedef struct {
    logic        op;
    logic [31:0] word;
  } beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             was_new;
    logic             full;
  } lookup_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [31:0]         s_tdata = '0;
  logic [0:0]          s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [15:0]         m_tdata;
  logic [1:0]          m_tuser;
  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_WORDS;
  logic [CFG_W-1:0]    cfg_data = '0;

  beat_t   word_queue[$];
  lookup_t lookup_queue[$];
  int      mismatches = 0;
  int      cycles = 0;
  int      send_gap = 0;
  logic    quiet = 1'b0;
  logic    long_req = 1'b0;

  // shadow copy of the hash set
  logic [2:0]       words_reg = 3'd1;
  logic [CFG_W-1:0] limit_reg = 13'd4096;
  int unsigned      heads[1 << HBITS];
  int unsigned      links[MAX_NODES_DEF + 1];
  logic [31:0]      store[(MAX_NODES_DEF + 1) * NWAY];
  logic [31:0]      vec_words[NWAY];
  logic [31:0]      vec_hash = '0;
  int unsigned      vec_pos = 0;
  logic             vec_op = 1'b0;
  int unsigned      nodes_used = 0;

  state_vector_hash_set i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int unsigned vec_len();
    if (words_reg == 3'd0) return 1;
    if (words_reg > NWAY) return NWAY;
    return words_reg;
  endfunction

  function automatic logic [31:0] hash_round(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> HBITS);
    return t * 32'd1234567 + 32'd5555555;
  endfunction

  // hash one word; on the last word of a vector, look up or insert it
  task automatic take_word(input logic op, input logic [31:0] w);
    int unsigned n, node, k, lim;
    logic [HBITS-1:0] bkt;
    logic hit;
    lookup_t res;
    n = vec_len();
    if (vec_pos == 0) begin
      vec_op = op;
      vec_hash = '0;
    end
    if (vec_pos < NWAY) vec_words[vec_pos] = w;
    vec_hash = hash_round(hash_round(vec_hash ^ w));
    vec_pos++;
    if (vec_pos < n) return;
    vec_pos = 0;
    bkt = vec_hash[HBITS-1:0];
    node = heads[bkt];
    hit = 1'b0;
    while (node != 0 && !hit) begin
      hit = 1'b1;
      for (k = 0; k < n; k++)
        if (store[node * NWAY + k] != vec_words[k]) hit = 1'b0;
      if (!hit) node = links[node];
    end
    res = '0;
    lim = (limit_reg > MAX_NODES_DEF) ? MAX_NODES_DEF : limit_reg;
    if (hit) begin
      res.idx = node[IDX_W-1:0];
    end else if (vec_op == OP_INSERT) begin
      node = nodes_used + 1;
      res.idx = node[IDX_W-1:0];
      if (node > lim) begin
        res.full = 1'b1;
      end else begin
        for (k = 0; k < n; k++) store[node * NWAY + k] = vec_words[k];
        links[node] = heads[bkt];
        heads[bkt] = node;
        nodes_used = node;
        res.was_new = 1'b1;
      end
    end
    lookup_queue.push_back(res);
  endtask

  // sender: feeds beats from the queue with random gaps
  always @(posedge clk) begin
    beat_t b;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (word_queue.size() > 0) begin
        b = word_queue.pop_front();
        s_tdata <= b.word;
        s_tuser <= b.op;
        s_tvalid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 16);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    int long_cnt;
    int rgap;
    logic long_done;
    if (rst) begin
      m_tready <= 1'b0;
      long_cnt = 0;
      rgap = 0;
      long_done = 1'b0;
    end else if (long_cnt > 0) begin
      long_cnt--;
      m_tready <= 1'b0;
    end else if (long_req && !long_done) begin
      long_done = 1'b1;
      long_cnt = 400;
      m_tready <= 1'b0;
    end else if (rgap > 0) begin
      rgap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) rgap = $urandom_range(1, 16);
    end
  end

  // accepted input beats go through the shadow set
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) take_word(s_tuser[0], s_tdata);
  end

  // result check
  always @(posedge clk) begin
    lookup_t exp_r, got;
    if (!rst && m_tvalid && m_tready) begin
      got.idx = m_tdata[IDX_W-1:0];
      got.was_new = m_tuser[0];
      got.full = m_tuser[1];
      if (lookup_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat idx=%0d", got.idx);
      end else begin
        exp_r = lookup_queue.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx=%0d new=%b full=%b got idx=%0d new=%b full=%b",
                     exp_r.idx, exp_r.was_new, exp_r.full, got.idx, got.was_new, got.full);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL state_vector_hash_set");
      $finish;
    end
  end

  // one write beat, framed by clock edges so back to back writes never collide
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_WORDS) words_reg = val[2:0];
    else limit_reg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // push one vector; w0 is the first word and wr fills the remaining words
  task automatic push_vec(input logic op, input logic [31:0] w0, input logic [31:0] wr);
    int unsigned k;
    for (k = 0; k < vec_len(); k++) word_queue.push_back('{op, (k == 0) ? w0 : wr});
  endtask

  function automatic logic [31:0] pick_word();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'h1000 + $urandom_range(0, 3);
  endfunction

  task automatic push_random(input int nvec);
    int i, k;
    logic op;
    for (i = 0; i < nvec; i++) begin
      op = ($urandom_range(0, 2) != 0) ? OP_INSERT : OP_FIND;
      for (k = 0; k < vec_len(); k++) word_queue.push_back('{op, pick_word()});
    end
  endtask

  task automatic drain();
    while (word_queue.size() > 0 || s_tvalid || lookup_queue.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    foreach (heads[i]) heads[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // longest vectors (out of range length), no room at all
    write_reg(REG_WORDS, 13'd7);
    write_reg(REG_MAX_NODES, 13'd0);
    push_vec(OP_INSERT, 32'h0, 32'h0);
    push_vec(OP_FIND, 32'h0, 32'h0);
    drain();

    // limit above range: inserts, duplicates, hits and misses
    write_reg(REG_MAX_NODES, 13'h1FFF);
    push_vec(OP_INSERT, 32'h0, 32'h0);
    push_vec(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_vec(OP_INSERT, 32'h0, 32'h0);
    push_vec(OP_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_vec(OP_FIND, 32'h5555_AAAA, 32'h0);
    push_vec(OP_INSERT, 32'hAAAA_5555, 32'h1);
    drain();

    // table full: new vector refused, known one still found
    write_reg(REG_MAX_NODES, nodes_used[CFG_W-1:0]);
    push_vec(OP_INSERT, 32'h1234_5678, 32'h9);
    push_vec(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_vec(OP_FIND, 32'h1234_5678, 32'h9);
    drain();

    // random: four words, with a long output stall
    write_reg(REG_WORDS, 13'd4);
    write_reg(REG_MAX_NODES, 13'd4096);
    long_req = 1'b1;
    push_random(150);
    drain();

    write_reg(REG_WORDS, 13'd3);
    write_reg(REG_MAX_NODES, nodes_used[CFG_W-1:0] + 13'd20);
    push_random(150);
    drain();

    write_reg(REG_WORDS, 13'd2);
    write_reg(REG_MAX_NODES, 13'd4096);
    push_random(200);
    drain();

    // one word per vector (length zero), tail without idling
    write_reg(REG_WORDS, 13'd0);
    write_reg(REG_MAX_NODES, nodes_used[CFG_W-1:0] + 13'd30);
    push_random(250);
    drain();
    write_reg(REG_WORDS, 13'd1);
    quiet = 1'b1;
    push_random(150);
    drain();

    if (mismatches == 0) begin
      $display("PASS state_vector_hash_set");
    end else begin
      $display("FAIL state_vector_hash_set");
    end
    $finish;
  end

endmodule

[files.f]
rtl/shv_pkg.sv
rtl/shv_hash.sv
rtl/shv_table.sv
rtl/state_vector_hash_set.sv
rtl/shv_checker.sv
sim/state_vector_hash_set_tb.sv
